@@ hw/rtl/zbps_pkg.sv @@
// Shared types and constants for the block-product address sequencer.
`timescale 1ns / 1ps

package zbps_pkg;

    localparam int IDX_W      = 10;
    localparam int LVL_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEVELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_MODE   = 2'd1;

    typedef struct packed {
        logic [LVL_W-1:0] levels;
        logic             zorder;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic last;
    } seq_stat_t;

endpackage

@@ hw/rtl/zbps_counter.sv @@
// Sequence counter and input stage register of the block-product address sequencer.
`timescale 1ns / 1ps

module zbps_counter #(
    parameter int MAX_LEVELS = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       restart,
    input  logic [zbps_pkg::LVL_W-1:0] levels,
    output zbps_pkg::seq_stat_t        stat,
    input  logic                       stage_ready,
    output logic [3*MAX_LEVELS-1:0]    cnt
);
    import zbps_pkg::*;

    localparam int CNT_W  = 3 * MAX_LEVELS;
    localparam int SPAN_W = $clog2(CNT_W + 1);

    logic [CNT_W-1:0]  counter_reg;
    logic [CNT_W-1:0]  counter_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              last_reg;
    logic              valid_reg;
    logic [SPAN_W-1:0] span;
    logic [CNT_W-1:0]  mask;
    logic [CNT_W-1:0]  cur;
    logic              cur_last;
    logic              accept;
    logic              stage_take;

    assign stage_take = valid_reg && stage_ready;
    assign in_ready   = !valid_reg || stage_ready;
    assign accept     = in_valid && in_ready;

    always_comb
    begin
        span = SPAN_W'({2'b00, levels} * 5'd3);
        for (int b = 0; b < CNT_W; b++)
        begin
            mask[b] = (SPAN_W'(b) < span);
        end
        cur          = (restart ? '0 : counter_reg) & mask;
        cur_last     = (cur == mask);
        counter_next = cur_last ? '0 : cur + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                counter_reg <= counter_next;
                valid_reg   <= 1'b1;
            end
            else if (stage_take)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cnt_reg  <= cur;
            last_reg <= cur_last;
        end
    end

    assign stat.valid = valid_reg;
    assign stat.last  = last_reg;
    assign cnt        = cnt_reg;

`ifndef SYNTH
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && restart |=> cnt_reg == '0)
        else $error("restart transaction did not start from zero");

    a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cur_last |=> counter_reg == '0)
        else $error("counter did not wrap after last triple");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !stage_ready && !accept |=> valid_reg && $stable(cnt_reg))
        else $error("stalled stage lost its count");
`endif

endmodule

@@ hw/rtl/zbps_index.sv @@
// Block index formation and result register of the block-product address sequencer.
`timescale 1ns / 1ps

module zbps_index #(
    parameter int MAX_LEVELS = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  zbps_pkg::seq_stat_t        stat,
    input  logic [3*MAX_LEVELS-1:0]    cnt,
    output logic                       stage_ready,
    input  zbps_pkg::cfg_t             cfg,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [zbps_pkg::IDX_W-1:0] a_index,
    output logic [zbps_pkg::IDX_W-1:0] b_index,
    output logic [zbps_pkg::IDX_W-1:0] c_index,
    output logic                       last
);
    import zbps_pkg::*;

    localparam int FULL_W = (2 * MAX_LEVELS > IDX_W) ? 2 * MAX_LEVELS : IDX_W;

    logic [MAX_LEVELS-1:0] row_i;
    logic [MAX_LEVELS-1:0] col_j;
    logic [MAX_LEVELS-1:0] inner_k;
    logic [IDX_W-1:0]      a_next;
    logic [IDX_W-1:0]      b_next;
    logic [IDX_W-1:0]      c_next;
    logic [IDX_W-1:0]      a_reg;
    logic [IDX_W-1:0]      b_reg;
    logic [IDX_W-1:0]      c_reg;
    logic                  last_reg;
    logic                  valid_reg;
    logic                  load;

    function automatic logic [IDX_W-1:0] form_index(
        input logic [MAX_LEVELS-1:0] row,
        input logic [MAX_LEVELS-1:0] col,
        input logic [LVL_W-1:0]      lv,
        input logic                  zorder
    );
        logic [FULL_W-1:0] w;
        w = '0;
        if (zorder)
        begin
            for (int b = 0; b < MAX_LEVELS; b++)
            begin
                w[2*b]   = col[b];
                w[2*b+1] = row[b];
            end
        end
        else
        begin
            w = (FULL_W'(row) << lv) | FULL_W'(col);
        end
        return w[IDX_W-1:0];
    endfunction

    always_comb
    begin
        for (int l = 0; l < MAX_LEVELS; l++)
        begin
            row_i[l]   = cnt[3*l+2];
            col_j[l]   = cnt[3*l+1];
            inner_k[l] = cnt[3*l];
        end
        a_next = form_index(row_i, inner_k, cfg.levels, cfg.zorder);
        b_next = form_index(inner_k, col_j, cfg.levels, cfg.zorder);
        c_next = form_index(row_i, col_j, cfg.levels, cfg.zorder);
    end

    assign stage_ready = !valid_reg || out_ready;
    assign load        = stat.valid && stage_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (stage_ready)
        begin
            valid_reg <= stat.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            last_reg <= stat.last;
        end
    end

    assign out_valid = valid_reg;
    assign a_index   = a_reg;
    assign b_index   = b_reg;
    assign c_index   = c_reg;
    assign last      = last_reg;

endmodule

@@ hw/rtl/zorder_block_product_sequencer_top.sv @@
// Top level of the block-product address sequencer: configuration registers and stages.
// Path: an accepted request is registered in the counter stage and then in the index stage,
// whose valid register drives out_valid.
// Throughput: one triple per cycle; in_ready drops only while both stages are full
// and out_ready is low.
// Reset: counter, block_levels, index_mode and both stage valids clear at once.
`timescale 1ns / 1ps

module zorder_block_product_sequencer_top #(
    parameter int MAX_LEVELS = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            restart,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [zbps_pkg::IDX_W-1:0]      a_index,
    output logic [zbps_pkg::IDX_W-1:0]      b_index,
    output logic [zbps_pkg::IDX_W-1:0]      c_index,
    output logic                            last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [zbps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [zbps_pkg::CFG_DATA_W-1:0] cfg_data
);
    import zbps_pkg::*;

    logic [LVL_W-1:0]          block_levels_reg;
    logic                      index_mode_reg;
    cfg_t                      cfg;
    seq_stat_t                 stat;
    logic                      stage_ready;
    logic [3*MAX_LEVELS-1:0]   cnt;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_levels_reg <= '0;
            index_mode_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BLOCK_LEVELS: block_levels_reg <= cfg_data[LVL_W-1:0];
                REG_INDEX_MODE:   index_mode_reg   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        cfg.levels = (32'(block_levels_reg) > MAX_LEVELS) ? LVL_W'(MAX_LEVELS)
                                                           : block_levels_reg;
        cfg.zorder = index_mode_reg;
    end

    zbps_counter #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_counter (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .restart     (restart),
        .levels      (cfg.levels),
        .stat        (stat),
        .stage_ready (stage_ready),
        .cnt         (cnt)
    );

    zbps_index #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_index (
        .clk         (clk),
        .rst_n       (rst_n),
        .stat        (stat),
        .cnt         (cnt),
        .stage_ready (stage_ready),
        .cfg         (cfg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .a_index     (a_index),
        .b_index     (b_index),
        .c_index     (c_index),
        .last        (last)
    );

endmodule

@@ tb/sv/tb_zorder_block_product_sequencer_top.sv @@
// Testbench for the block-product address sequencer: queued transactions, predicted triples, random idling.
`timescale 1ns / 1ps

module tb_zorder_block_product_sequencer_top;
    import zbps_pkg::*;

    localparam int MAX_LEVELS = 5;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        logic             last;
    } triple_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  restart = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [IDX_W-1:0]      a_index;
    logic [IDX_W-1:0]      b_index;
    logic [IDX_W-1:0]      c_index;
    logic                  last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                  pending_restarts[$];
    triple_t               triples_due[$];
    int unsigned           queued_total = 0;
    int unsigned           accepted_total = 0;
    int unsigned           error_count = 0;
    int unsigned           cycle_count = 0;
    int unsigned           src_idle_pct = 0;
    int unsigned           snk_stall_pct = 0;
    logic                  hold_req = 1'b0;
    logic [15:0]           hold_left = '0;

    logic [14:0]           seq_count = '0;
    logic [LVL_W-1:0]      lvl_reg = '0;
    logic                  mode_reg = 1'b0;

    zorder_block_product_sequencer_top #(
        .MAX_LEVELS(MAX_LEVELS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .restart(restart),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .a_index(a_index),
        .b_index(b_index),
        .c_index(c_index),
        .last(last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [IDX_W-1:0] block_addr(input int unsigned row,
                                                    input int unsigned col,
                                                    input int unsigned lv);
        int unsigned r;
        r = 0;
        if (!mode_reg)
        begin
            r = (row << lv) | col;
        end
        else
        begin
            for (int b = 0; b < lv; b++)
            begin
                r |= ((col >> b) & 1) << (2 * b);
                r |= ((row >> b) & 1) << (2 * b + 1);
            end
        end
        return r[IDX_W-1:0];
    endfunction

    function automatic triple_t next_triple(input logic rs);
        int unsigned lv;
        int unsigned mask;
        int unsigned cnt;
        int unsigned row;
        int unsigned col;
        int unsigned inner;
        triple_t     t;
        lv = (lvl_reg > MAX_LEVELS) ? MAX_LEVELS : lvl_reg;
        mask = (32'd1 << (3 * lv)) - 1;
        if (rs)
        begin
            seq_count = '0;
        end
        cnt = seq_count & mask;
        row = 0;
        col = 0;
        inner = 0;
        for (int l = 0; l < lv; l++)
        begin
            row   |= ((cnt >> (3 * l + 2)) & 1) << l;
            col   |= ((cnt >> (3 * l + 1)) & 1) << l;
            inner |= ((cnt >> (3 * l)) & 1) << l;
        end
        t.a = block_addr(row, inner, lv);
        t.b = block_addr(inner, col, lv);
        t.c = block_addr(row, col, lv);
        t.last = (cnt == mask);
        seq_count = t.last ? 15'd0 : 15'((cnt + 1) & mask);
        return t;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                triples_due.push_back(next_triple(restart));
                accepted_total++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_restarts.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    in_valid <= 1'b1;
                    restart <= pending_restarts.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left <= 16'(HOLD_CYCLES);
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 16'd1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        triple_t exp_t;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (triples_due.size() == 0)
                begin
                    $error("unexpected transaction: a_index %0d b_index %0d c_index %0d last %0d",
                           a_index, b_index, c_index, last);
                    error_count++;
                end
                else
                begin
                    exp_t = triples_due.pop_front();
                    if (a_index !== exp_t.a)
                    begin
                        $error("a_index mismatch: expected %0d, got %0d", exp_t.a, a_index);
                        error_count++;
                    end
                    if (b_index !== exp_t.b)
                    begin
                        $error("b_index mismatch: expected %0d, got %0d", exp_t.b, b_index);
                        error_count++;
                    end
                    if (c_index !== exp_t.c)
                    begin
                        $error("c_index mismatch: expected %0d, got %0d", exp_t.c, c_index);
                        error_count++;
                    end
                    if (last !== exp_t.last)
                    begin
                        $error("last mismatch: expected %0d, got %0d", exp_t.last, last);
                        error_count++;
                    end
                end
            end
            out_ready <= (hold_left == 0) && !hold_req && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BLOCK_LEVELS: lvl_reg = data;
            REG_INDEX_MODE:   mode_reg = data[0];
            default:          ;
        endcase
    endtask

    task automatic queue_item(input logic rs);
        pending_restarts.push_back(rs);
        queued_total++;
    endtask

    task automatic drain();
        do
        begin
            @(posedge clk);
        end
        while (accepted_total != queued_total || triples_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_idling(input int unsigned src_pct, input int unsigned snk_pct);
        @(posedge clk);
        src_idle_pct <= src_pct;
        snk_stall_pct <= snk_pct;
    endtask

    initial
    begin
        int unsigned r;
        int unsigned n;
        logic [CFG_DATA_W-1:0] lv_data;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // one-block grid straight out of reset
        queue_item(1'b0);
        queue_item(1'b1);
        queue_item(1'b0);
        drain();

        // full two-by-two sequence with wrap, row-major
        write_reg(REG_BLOCK_LEVELS, 3'd1);
        repeat (9) queue_item(1'b0);
        drain();

        // Z-order with a restart mid-sequence
        write_reg(REG_INDEX_MODE, 3'd3);
        queue_item(1'b0);
        queue_item(1'b0);
        queue_item(1'b0);
        queue_item(1'b1);
        queue_item(1'b0);
        drain();

        // saturate the level count
        write_reg(REG_BLOCK_LEVELS, 3'd7);
        write_reg(REG_INDEX_MODE, 3'd2);
        repeat (3) queue_item(1'b0);
        drain();

        write_reg(REG_INDEX_MODE, 3'd1);
        write_reg(REG_UNUSED, 3'd7);
        repeat (2) queue_item(1'b0);
        drain();

        // shrink the level count mid-sequence
        write_reg(REG_BLOCK_LEVELS, 3'd2);
        repeat (3) queue_item(1'b0);
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: set_idling(0, 0);
                1: set_idling(69, 0);
                2: set_idling(0, 69);
                default: set_idling(33, 33);
            endcase
            r = $urandom_range(9);
            if (r < 1)
                lv_data = 3'd0;
            else if (r < 4)
                lv_data = 3'd1;
            else if (r < 7)
                lv_data = 3'd2;
            else if (r < 8)
                lv_data = 3'd3;
            else
                lv_data = 3'($urandom_range(7, 4));
            write_reg(REG_BLOCK_LEVELS, lv_data);
            write_reg(REG_INDEX_MODE, 3'($urandom_range(7)));
            n = $urandom_range(120, 70);
            for (int k = 0; k < n; k++)
            begin
                queue_item($urandom_range(31) == 0);
            end
            if (ph == 4)
            begin
                @(posedge clk);
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            drain();
        end

        set_idling(0, 0);
        drain();
        repeat (10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
